### rtl/core/http_chunked_body_decoder_unit_macros.svh
// assertion macros for the chunked body decoder
// used by rtl/core modules that carry concurrent checks
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define HCBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge outside reset
`define HCBD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/hcbd_pkg.sv
// types, codes and character helpers for the chunked body decoder
// no dependencies
`timescale 1ns / 1ps

package hcbd_pkg;

  typedef enum logic [3:0] {
    PH_SIZE_FIRST,
    PH_SIZE_DIGITS,
    PH_SIZE_EXT,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_TRAILER,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_SIZE   = 3'd1,
    ERR_NO_CRLF    = 3'd2,
    ERR_BODY_LARGE = 3'd3,
    ERR_LINE_LONG  = 3'd4
  } err_t;

  localparam logic CFG_MAX_BODY = 1'b0;
  localparam logic CFG_MAX_LINE = 1'b1;

  localparam logic [31:0] MAX_BODY_RST = 32'd16777216;
  localparam logic [15:0] MAX_LINE_RST = 16'd8192;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  localparam int RES_W = 13;

  // one decoded result, data_valid in the lowest bit
  typedef struct packed {
    err_t       error_code;
    logic       body_done;
    logic [7:0] data_byte;
    logic       data_valid;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      h.val = 4'(b - 8'h30);
    end else if (b inside {[8'h61:8'h66]}) begin
      h.val = 4'(b - 8'h57);
    end else if (b inside {[8'h41:8'h46]}) begin
      h.val = 4'(b - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

### rtl/core/hcbd_out_buf.sv
// two-entry output buffer for decoded results
// depends on hcbd_pkg for the result type
`timescale 1ns / 1ps

module hcbd_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hcbd_pkg::res_t push_data,
  output logic          space,
  output logic          out_valid,
  output hcbd_pkg::res_t out_data,
  input  logic          out_ready
);
  import hcbd_pkg::*;

  logic main_v_r;
  logic skid_v_r;
  res_t main_r;
  res_t skid_r;
  logic pop;

  assign pop       = main_v_r & out_ready;
  assign space     = ~skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      if (!main_v_r) begin
        main_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_r <= skid_v_r ? skid_r : push_data;
    end else if (push) begin
      if (!main_v_r) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

endmodule

### rtl/core/http_chunked_body_decoder_unit.sv
// result: each input transfer's result is registered in hcbd_out_buf and driven onto out_tdata
// throughput: one byte per cycle while the output buffer has space; the two-entry buffer keeps in_tready
//   high while one finished result waits on out_tready
// reset: rst_n clears the parse state and loads max_body_bytes = 16777216 and
//   max_line_bytes = 8192; restart in in_tuser clears the parse state only
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_unit_macros.svh"

module http_chunked_body_decoder_unit #(
  parameter int SIZE_BITS = 32,
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  input  logic        in_tuser,   // restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // data_valid, data_byte, body_done, error_code, zero pad
);
  import hcbd_pkg::*;

  localparam int CW = (SIZE_BITS > 32) ? SIZE_BITS : 32;
  localparam int LW = (LINE_BITS > 16) ? LINE_BITS : 16;

  logic [31:0]          max_body_r;
  logic [15:0]          max_line_r;
  phase_t               phase_r, phase_nxt, cur_phase;
  logic                 saw_cr_r, saw_cr_nxt, cur_saw;
  logic [SIZE_BITS-1:0] chunk_r, chunk_nxt, cur_chunk;
  logic [31:0]          total_r, total_nxt, cur_total;
  logic [LINE_BITS-1:0] len_r, len_nxt, cur_len;
  err_t                 err_r, err_nxt, cur_err;

  logic                 in_fire;
  logic [7:0]           b;
  hex_t                 hx;
  logic [LINE_BITS-1:0] len_p1;
  logic                 full0, full1;
  logic                 lb_end, lb_fail, lb_saw;
  logic [LINE_BITS-1:0] lb_len;
  logic [31:0]          body_room;
  logic                 too_large;
  logic [SIZE_BITS-1:0] chunk_dec;
  logic                 buf_space;
  res_t                 res, out_res;

  assign in_fire   = in_tvalid & in_tready;
  assign in_tready = buf_space;
  assign b         = in_tdata;
  assign hx        = hex_decode(b);

  // restart acts on the state before this byte
  assign cur_phase = in_tuser ? PH_SIZE_FIRST : phase_r;
  assign cur_saw   = in_tuser ? 1'b0 : saw_cr_r;
  assign cur_chunk = in_tuser ? '0 : chunk_r;
  assign cur_total = in_tuser ? '0 : total_r;
  assign cur_len   = in_tuser ? '0 : len_r;
  assign cur_err   = in_tuser ? ERR_NONE : err_r;

  assign len_p1    = cur_len + {{(LINE_BITS-1){1'b0}}, 1'b1};
  assign full0     = (LW'(cur_len) >= LW'(max_line_r)) || (&cur_len);
  assign full1     = (LW'(len_p1) >= LW'(max_line_r)) || (&len_p1);
  assign body_room = max_body_r - cur_total;
  assign too_large = CW'(cur_chunk) > CW'(body_room);
  assign chunk_dec = cur_chunk - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  // one byte of an ignored line: CR LF ends it, a lone CR counts as content
  always_comb begin
    lb_end  = 1'b0;
    lb_fail = 1'b0;
    lb_saw  = 1'b0;
    lb_len  = cur_len;
    if (cur_saw && b == CH_LF) begin
      lb_end = 1'b1;
    end else if (cur_saw) begin
      if (full0) begin
        lb_fail = 1'b1;
      end else if (b == CH_CR) begin
        lb_saw = 1'b1;
        lb_len = len_p1;
      end else if (full1) begin
        lb_fail = 1'b1;
        lb_len  = len_p1;
      end else begin
        lb_len = len_p1 + {{(LINE_BITS-1){1'b0}}, 1'b1};
      end
    end else if (b == CH_CR) begin
      lb_saw = 1'b1;
    end else if (full0) begin
      lb_fail = 1'b1;
    end else begin
      lb_len = len_p1;
    end
  end

  // next state
  always_comb begin
    phase_nxt  = cur_phase;
    saw_cr_nxt = cur_saw;
    chunk_nxt  = cur_chunk;
    total_nxt  = cur_total;
    len_nxt    = cur_len;
    err_nxt    = cur_err;
    case (cur_phase)
      PH_SIZE_FIRST: begin
        if (!hx.ok) begin
          err_nxt   = ERR_BAD_SIZE;
          phase_nxt = PH_ERROR;
        end else begin
          saw_cr_nxt = 1'b0;
          chunk_nxt  = SIZE_BITS'(hx.val);
          if (max_line_r == '0) begin
            len_nxt   = '0;
            err_nxt   = ERR_LINE_LONG;
            phase_nxt = PH_ERROR;
          end else begin
            len_nxt   = {{(LINE_BITS-1){1'b0}}, 1'b1};
            phase_nxt = PH_SIZE_DIGITS;
          end
        end
      end
      PH_SIZE_DIGITS, PH_SIZE_EXT: begin
        if (cur_phase == PH_SIZE_DIGITS && hx.ok) begin
          if (cur_chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
            err_nxt   = ERR_BAD_SIZE;
            phase_nxt = PH_ERROR;
          end else begin
            chunk_nxt = {cur_chunk[SIZE_BITS-5:0], hx.val};
            if (full0) begin
              err_nxt   = ERR_LINE_LONG;
              phase_nxt = PH_ERROR;
            end else begin
              len_nxt = len_p1;
            end
          end
        end else begin
          saw_cr_nxt = lb_saw;
          len_nxt    = lb_len;
          phase_nxt  = PH_SIZE_EXT;
          if (lb_fail) begin
            err_nxt   = ERR_LINE_LONG;
            phase_nxt = PH_ERROR;
          end else if (lb_end) begin
            len_nxt = '0;
            if (cur_chunk == '0) begin
              phase_nxt = PH_TRAILER;
            end else if (too_large) begin
              err_nxt   = ERR_BODY_LARGE;
              phase_nxt = PH_ERROR;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        total_nxt = cur_total + 32'd1;
        chunk_nxt = chunk_dec;
        if (chunk_dec == '0) begin
          phase_nxt = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (b == CH_CR) begin
          phase_nxt = PH_DATA_LF;
        end else begin
          err_nxt   = ERR_NO_CRLF;
          phase_nxt = PH_ERROR;
        end
      end
      PH_DATA_LF: begin
        if (b == CH_LF) begin
          phase_nxt  = PH_SIZE_FIRST;
          saw_cr_nxt = 1'b0;
          len_nxt    = '0;
        end else begin
          err_nxt   = ERR_NO_CRLF;
          phase_nxt = PH_ERROR;
        end
      end
      PH_TRAILER: begin
        saw_cr_nxt = lb_saw;
        len_nxt    = lb_len;
        if (lb_fail) begin
          err_nxt   = ERR_LINE_LONG;
          phase_nxt = PH_ERROR;
        end else if (lb_end) begin
          len_nxt = '0;
          if (cur_len == '0) begin
            phase_nxt = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result for this byte
  always_comb begin
    res            = '0;
    res.error_code = err_nxt;
    case (cur_phase)
      PH_DATA: begin
        res.data_valid = 1'b1;
        res.data_byte  = b;
      end
      PH_TRAILER: begin
        res.body_done = lb_end && !lb_fail && (cur_len == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAX_BODY_RST;
      max_line_r <= MAX_LINE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAX_BODY: max_body_r <= cfg_wdata;
        CFG_MAX_LINE: max_line_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIZE_FIRST;
      saw_cr_r <= 1'b0;
      chunk_r  <= '0;
      total_r  <= '0;
      len_r    <= '0;
      err_r    <= ERR_NONE;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      saw_cr_r <= saw_cr_nxt;
      chunk_r  <= chunk_nxt;
      total_r  <= total_nxt;
      len_r    <= len_nxt;
      err_r    <= err_nxt;
    end
  end

  hcbd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res),
    .space     (buf_space),
    .out_valid (out_tvalid),
    .out_data  (out_res),
    .out_ready (out_tready)
  );

  assign out_tdata = {{(16-RES_W){1'b0}}, out_res};

  `HCBD_ASSERT_IMPL(a_stall_holds_result, !in_tready, out_tvalid, "input stalled with no result pending")
  `HCBD_ASSERT_IMPL(a_error_sticky_code, phase_r == PH_ERROR, err_r != ERR_NONE, "error phase without a code")
  `HCBD_ASSERT_IMPL(a_data_nonzero, phase_r == PH_DATA, chunk_r != '0, "data phase with no bytes left")
  `HCBD_ASSERT_IMPL(a_done_phase, in_fire && res.body_done, ##1 phase_r == PH_DONE, "body end not recorded")
  `HCBD_ASSERT_IMPL(a_payload_clean, out_tvalid && out_res.data_valid, out_res.error_code == ERR_NONE && !out_res.body_done, "payload byte with error or end flag")

endmodule

### sim/hcbd_decode_checker.sv
// checker for the chunked body decoder: tracks limit writes, decodes every input transfer
// into an expected result and compares each output transfer field by field
// depends on hcbd_pkg
`timescale 1ns / 1ps

module hcbd_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  input  logic        in_tuser,   // restart
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // data_valid, data_byte, body_done, error_code, zero pad
  output int          mismatch_count,
  output int          results_pending,
  output int          parsed_bytes
);
  import hcbd_pkg::*;

  typedef enum {LN_MORE, LN_END, LN_FAIL} line_step_t;

  logic [31:0] lim_body;
  logic [15:0] lim_line;

  phase_t      ph;
  logic        saw_cr;
  logic [31:0] chunk_left;
  logic [31:0] body_sum;
  logic [15:0] line_len;
  err_t        sticky;

  res_t decoded_fifo[$];

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
    return -1;
  endfunction

  function automatic void set_error(input err_t code);
    sticky = code;
    ph = PH_ERROR;
  endfunction

  function automatic logic take_line_byte();
    if (line_len >= lim_line || line_len == 16'hffff) begin
      set_error(ERR_LINE_LONG);
      return 1'b0;
    end
    line_len++;
    return 1'b1;
  endfunction

  // a line ends only on cr directly followed by lf; a lone cr is a line byte
  function automatic line_step_t eat_line_byte(input logic [7:0] b);
    if (saw_cr && b == CH_LF) begin
      saw_cr = 1'b0;
      return LN_END;
    end
    if (saw_cr) begin
      saw_cr = 1'b0;
      if (!take_line_byte()) return LN_FAIL;
    end
    if (b == CH_CR) begin
      saw_cr = 1'b1;
      return LN_MORE;
    end
    return take_line_byte() ? LN_MORE : LN_FAIL;
  endfunction

  function automatic void close_size_line();
    line_len = '0;
    if (chunk_left == 0) begin
      ph = PH_TRAILER;
    end else if (chunk_left > 32'(lim_body - body_sum)) begin
      set_error(ERR_BODY_LARGE);
    end else begin
      ph = PH_DATA;
    end
  endfunction

  function automatic void clear_parse();
    ph         = PH_SIZE_FIRST;
    saw_cr     = 1'b0;
    chunk_left = '0;
    body_sum   = '0;
    line_len   = '0;
    sticky     = ERR_NONE;
  endfunction

  function automatic res_t decode_byte(input logic [7:0] b, input logic rs);
    res_t r;
    int   hv;
    r = '0;
    if (rs) clear_parse();
    hv = hex_nibble(b);
    case (ph)
      PH_SIZE_FIRST: begin
        if (hv < 0) begin
          set_error(ERR_BAD_SIZE);
        end else begin
          saw_cr     = 1'b0;
          line_len   = '0;
          chunk_left = 32'(hv);
          if (take_line_byte()) ph = PH_SIZE_DIGITS;
        end
      end
      PH_SIZE_DIGITS: begin
        if (hv >= 0) begin
          // another digit would push the size past 32 bits
          if (chunk_left[31:28] != 4'd0) begin
            set_error(ERR_BAD_SIZE);
          end else begin
            chunk_left = {chunk_left[27:0], 4'(hv)};
            void'(take_line_byte());
          end
        end else begin
          ph = PH_SIZE_EXT;
          if (eat_line_byte(b) == LN_END) close_size_line();
        end
      end
      PH_SIZE_EXT: begin
        if (eat_line_byte(b) == LN_END) close_size_line();
      end
      PH_DATA: begin
        r.data_valid = 1'b1;
        r.data_byte  = b;
        body_sum++;
        chunk_left--;
        if (chunk_left == 0) ph = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (b == CH_CR) ph = PH_DATA_LF;
        else set_error(ERR_NO_CRLF);
      end
      PH_DATA_LF: begin
        if (b == CH_LF) begin
          ph       = PH_SIZE_FIRST;
          saw_cr   = 1'b0;
          line_len = '0;
        end else begin
          set_error(ERR_NO_CRLF);
        end
      end
      PH_TRAILER: begin
        if (eat_line_byte(b) == LN_END) begin
          if (line_len == 0) begin
            r.body_done = 1'b1;
            ph = PH_DONE;
          end
          line_len = '0;
        end
      end
      default: ;
    endcase
    r.error_code = sticky;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      lim_body = MAX_BODY_RST;
      lim_line = MAX_LINE_RST;
      clear_parse();
      decoded_fifo.delete();
      results_pending <= 0;
    end else begin
      // a byte taken at the same edge as a limit write still sees the old limit
      if (in_tvalid && in_tready) begin
        parsed_bytes <= parsed_bytes + 1;
        decoded_fifo.push_back(decode_byte(in_tdata, in_tuser));
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MAX_BODY: lim_body = cfg_wdata;
          CFG_MAX_LINE: lim_line = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[RES_W-1:0]);
        if (decoded_fifo.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected (%h)", out_tdata));
        end else begin
          want = decoded_fifo.pop_front();
          if (got.data_valid !== want.data_valid)
            report_mismatch($sformatf("data_valid got %0b want %0b",
                                      got.data_valid, want.data_valid));
          if (got.data_byte !== want.data_byte)
            report_mismatch($sformatf("data_byte got %h want %h",
                                      got.data_byte, want.data_byte));
          if (got.body_done !== want.body_done)
            report_mismatch($sformatf("body_done got %0b want %0b",
                                      got.body_done, want.body_done));
          if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code got %0d want %0d",
                                      got.error_code, want.error_code));
        end
      end
      results_pending <= decoded_fifo.size();
    end
  end

endmodule

### sim/tb_top.sv
// top of the chunked body decoder bench: clock, reset, limit writes and byte stimulus
// built from chunked messages; depends on hcbd_pkg, the decoder and hcbd_decode_checker
`timescale 1ns / 1ps

module tb_top;
  import hcbd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = CFG_MAX_BODY;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // in_byte
  logic        in_tuser = 1'b0; // restart
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // data_valid, data_byte, body_done, error_code, zero pad

  int          mismatch_count;
  int          results_pending;
  int          parsed_bytes;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  logic [7:0] msg_q[$];

  http_chunked_body_decoder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  hcbd_decode_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending),
    .parsed_bytes    (parsed_bytes)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic push_item(input logic [7:0] b, input logic rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= rs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // restart on the first byte, and now and then in the middle when noisy
  task automatic send_message(input bit noisy);
    for (int k = 0; k < msg_q.size(); k++)
      push_item(msg_q[k], k == 0 || (noisy && $urandom_range(199) == 0));
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [31:0] body, input logic [15:0] line);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_MAX_BODY;
    cfg_wdata <= body;
    @(posedge clk);
    cfg_addr  <= CFG_MAX_LINE;
    cfg_wdata <= {16'd0, line};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit up);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (up ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // '^' stands for cr and '~' for lf
  task automatic put_str(input string s);
    for (int k = 0; k < s.len(); k++) begin
      case (s[k])
        "^":     msg_q.push_back(CH_CR);
        "~":     msg_q.push_back(CH_LF);
        default: msg_q.push_back(s[k]);
      endcase
    end
  endtask

  task automatic put_crlf();
    msg_q.push_back(CH_CR);
    msg_q.push_back(CH_LF);
  endtask

  task automatic put_size(input logic [31:0] v);
    int nd;
    bit up;
    nd = 8;
    while (nd > 1 && v[4*(nd-1) +: 4] == 4'd0) nd--;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) msg_q.push_back(8'h30);
    up = 1'($urandom_range(1));
    for (int k = nd - 1; k >= 0; k--) msg_q.push_back(hex_char(v[4*k +: 4], up));
  endtask

  // printable text with an occasional lone cr
  task automatic put_text(input int n);
    repeat (n)
      msg_q.push_back(($urandom_range(15) == 0) ? CH_CR : 8'($urandom_range(8'h20, 8'h7e)));
  endtask

  // optional chunk extension or trailing spaces, then crlf
  task automatic put_line_end();
    case ($urandom_range(9))
      0, 1: begin
        msg_q.push_back(8'h3b);
        repeat ($urandom_range(1, 6))
          msg_q.push_back(($urandom_range(5) == 0) ? 8'h3d : 8'(8'h61 + $urandom_range(25)));
      end
      2: repeat ($urandom_range(1, 3)) msg_q.push_back(8'h20);
      default: ;
    endcase
    put_crlf();
  endtask

  task automatic build_message();
    int kind;
    int sz;
    int pos;
    msg_q.delete();
    kind = $urandom_range(99);
    if (kind < 85) begin
      repeat ($urandom_range(3)) begin
        sz = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        put_size(sz);
        put_line_end();
        repeat (sz) msg_q.push_back(rand_byte());
        put_crlf();
      end
      put_size(0);
      put_line_end();
      repeat ($urandom_range(2)) begin
        put_text($urandom_range(8));
        put_crlf();
      end
      put_crlf();
      repeat ($urandom_range(2)) msg_q.push_back(rand_byte());
      // damaged message: one byte replaced, inserted, dropped, or a cut tail
      if (kind >= 65) begin
        pos = $urandom_range(1, msg_q.size() - 1);
        case ($urandom_range(3))
          0:       msg_q[pos] = rand_byte();
          1:       msg_q.insert(pos, rand_byte());
          2:       msg_q.delete(pos);
          default: while (msg_q.size() > pos) void'(msg_q.pop_back());
        endcase
      end
    end else if (kind < 93) begin
      // long chunk size, up to ten digits
      msg_q.push_back(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))));
      repeat ($urandom_range(6, 9))
        msg_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
      put_line_end();
      repeat ($urandom_range(4)) msg_q.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(1, 12)) msg_q.push_back(rand_byte());
    end
  endtask

  task automatic run_segment(input logic [31:0] body, input logic [15:0] line,
                             input int unsigned idle_pct, input int unsigned stall_pct,
                             input int target);
    int start;
    quiesce();
    set_limits(body, line);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = parsed_bytes;
    while (parsed_bytes - start < target) begin
      build_message();
      send_message(1'b1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_limits(32'd16, 16'd4);

    // size line with extension and lone cr, one data byte, final chunk, empty trailer,
    // then a byte after the end of the body
    msg_q.delete();
    put_str("1;^x^~");
    msg_q.push_back(8'hff);
    put_str("^~0^~^~");
    msg_q.push_back(8'h00);
    send_message(1'b0);
    // bad first size byte, then a byte while the error sticks
    msg_q.delete();
    put_str("gF");
    send_message(1'b0);
    // data not followed by crlf
    msg_q.delete();
    put_str("1^~");
    msg_q.push_back(8'h00);
    put_str("X");
    send_message(1'b0);
    // chunk larger than the body limit
    msg_q.delete();
    put_str("11^~");
    send_message(1'b0);
    // size line longer than the line limit
    msg_q.delete();
    put_str("ABCDE");
    send_message(1'b0);
    // empty size line
    msg_q.delete();
    put_str("^");
    send_message(1'b0);

    run_segment(32'hffff_ffff, 16'hffff,  0,  0, 280);
    run_segment(32'd0,         16'd0,     0,  0,  30);
    run_segment(32'd100,       16'd12,   78,  0, 280);
    run_segment(32'd16777216,  16'd8192, 78,  0, 250);
    run_segment(32'd300,       16'd6,     0, 78, 250);
    run_segment(32'd1,         16'd1,     0, 78,  60);
    run_segment(32'd50,        16'd20,   25, 25, 280);
    run_segment(32'hffff_ffff, 16'd3,    25, 25, 220);
    quiesce();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
